FILE: rtl/ketimer_pkg.sv
// Shared types and codes for the keyed event timer table.
package ketimer_pkg;

    localparam logic [2:0] REQ_CREATE = 3'd0;
    localparam logic [2:0] REQ_UPDATE = 3'd1;
    localparam logic [2:0] REQ_DELETE = 3'd2;
    localparam logic [2:0] REQ_QUERY  = 3'd3;
    localparam logic [2:0] REQ_TICK   = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_INVAL    = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    localparam logic KIND_DONE  = 1'b0;
    localparam logic KIND_FIRED = 1'b1;

    typedef struct packed {
        logic [31:0] cnt;
        logic [7:0]  task_id;
        logic [31:0] ev;
    } entry_t;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SWEEP  = 3'b010,
        S_REPORT = 3'b100
    } state_t;

endpackage

FILE: rtl/ketimer_cell.sv
// One table slot; the ring rotates entries one slot per cycle during a sweep.
module ketimer_cell
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  shift,
    input  ketimer_pkg::entry_t   din,
    output ketimer_pkg::entry_t   dout
);

    logic [31:0] cnt_reg;
    logic [7:0]  task_reg;
    logic [31:0] ev_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (shift)
        begin
            cnt_reg <= din.cnt;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            task_reg <= din.task_id;
            ev_reg   <= din.ev;
        end
    end

    assign dout.cnt     = cnt_reg;
    assign dout.task_id = task_reg;
    assign dout.ev      = ev_reg;

endmodule

FILE: rtl/keyed_event_timer_table.sv
// Top level of the keyed event timer table.
// A request keeps busy high for one full rotation of the slot ring, which
// passes one slot a cycle through the head logic (match, reload, free,
// decrement), and then for the report state. A create that finds no
// matching key but does find a free slot needs a second rotation to fill the
// first free slot. Results are registered and show as one-cycle strobes in
// the cycle after the head logic makes them. Expiry notices therefore come
// out in slot order during the rotation. The completion, or the final notice,
// comes in the same cycle in which busy drops. The receiver cannot stall.
// Requests are handled one at a time.
module keyed_event_timer_table
#(
    parameter int TIMERS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  req_type,
    input  logic [7:0]  task_id,
    input  logic [31:0] event_req,
    input  logic [31:0] reload,
    input  logic [7:0]  elapsed,
    input  logic        cfg_we,
    input  logic [8:0]  cfg_data,
    output logic        strobe,
    output logic        kind,
    output logic [1:0]  status,
    output logic [7:0]  fired_task,
    output logic [31:0] fired_event,
    output logic [31:0] remaining,
    output logic        last
);

    localparam int IW = (TIMERS > 1) ? $clog2(TIMERS) : 1;

    ketimer_pkg::entry_t ring [TIMERS];
    ketimer_pkg::entry_t head_in;
    logic                shift;

    ketimer_pkg::state_t state_reg, state_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [8:0]    limit_reg;
    logic [2:0]    req_reg;
    logic [7:0]    task_reg;
    logic [31:0]   ev_reg;
    logic [31:0]   rel_reg;
    logic [7:0]    el_reg;
    logic          bad_reg;
    logic          done_reg, done_next;
    logic          freeseen_reg, freeseen_next;
    logic [31:0]   rem_reg, rem_next;

    // deferred expiry notice, so last can be set on the final one
    logic          pend_reg, pend_next;
    logic [7:0]    pt_reg, pt_next;
    logic [31:0]   pe_reg, pe_next;

    // A match may sit after the first free slot, so a create without a match
    // fills the first free slot in a second rotation.
    logic          fill_reg, fill_next;
    ketimer_pkg::entry_t fill_entry;

    logic          o_stb, o_kind, o_last;
    logic [1:0]    o_st;
    logic [7:0]    o_task;
    logic [31:0]   o_ev, o_rem;

    genvar g;
    generate
        for (g = 0; g < TIMERS; g++)
        begin : g_cell
            ketimer_cell u_cell
            (
                .clk   (clk),
                .rst_n (rst_n),
                .shift (shift),
                .din   ((g == 0) ? head_in : ring[(g == 0) ? 0 : g-1]),
                .dout  (ring[g])
            );
        end
    endgenerate

    ketimer_pkg::entry_t tail;
    logic match, isfree;
    assign tail   = ring[TIMERS-1];
    assign isfree = (tail.cnt == '0);
    assign match  = !isfree && (tail.task_id == task_reg) && (tail.ev == ev_reg);
    assign shift  = (state_reg == ketimer_pkg::S_SWEEP);
    assign busy   = (state_reg != ketimer_pkg::S_IDLE);

    always_comb
    begin
        fill_entry.cnt     = rel_reg;
        fill_entry.task_id = task_reg;
        fill_entry.ev      = ev_reg;
    end

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        done_next     = done_reg;
        freeseen_next = freeseen_reg;
        fill_next     = fill_reg;
        rem_next      = rem_reg;
        pend_next     = pend_reg;
        pt_next       = pt_reg;
        pe_next       = pe_reg;
        head_in       = tail;
        o_stb = 1'b0; o_kind = ketimer_pkg::KIND_DONE; o_st = ketimer_pkg::ST_OK;
        o_task = '0; o_ev = '0; o_rem = '0; o_last = 1'b0;
        case (state_reg)
            ketimer_pkg::S_IDLE:
            begin
                if (start)
                begin
                    idx_next      = '0;
                    done_next     = 1'b0;
                    freeseen_next = 1'b0;
                    fill_next     = 1'b0;
                    rem_next      = '0;
                    pend_next     = 1'b0;
                    state_next    = ketimer_pkg::S_SWEEP;
                end
            end
            ketimer_pkg::S_SWEEP:
            begin
                if (fill_reg)
                begin
                    if (isfree && !done_reg)
                    begin
                        head_in   = fill_entry;
                        done_next = 1'b1;
                    end
                end
                else
                begin
                    case (req_reg)
                        ketimer_pkg::REQ_TICK:
                        begin
                            if (!isfree && el_reg != '0)
                            begin
                                head_in.cnt = (tail.cnt >= {24'd0, el_reg}) ?
                                              tail.cnt - {24'd0, el_reg} : '0;
                                if (head_in.cnt == '0)
                                begin
                                    if (pend_reg)
                                    begin
                                        o_stb = 1'b1; o_kind = ketimer_pkg::KIND_FIRED;
                                        o_task = pt_reg; o_ev = pe_reg;
                                    end
                                    pend_next = 1'b1;
                                    pt_next   = tail.task_id;
                                    pe_next   = tail.ev;
                                end
                            end
                        end
                        ketimer_pkg::REQ_CREATE, ketimer_pkg::REQ_UPDATE:
                        begin
                            if (!bad_reg && match)
                            begin
                                head_in.cnt = rel_reg;
                                done_next   = 1'b1;
                            end
                            if (isfree && !freeseen_reg)
                            begin
                                freeseen_next = 1'b1;
                            end
                        end
                        ketimer_pkg::REQ_DELETE:
                        begin
                            if (!bad_reg && match)
                            begin
                                head_in.cnt = '0;
                                done_next   = 1'b1;
                            end
                        end
                        ketimer_pkg::REQ_QUERY:
                        begin
                            if (!bad_reg && match)
                            begin
                                rem_next  = tail.cnt;
                                done_next = 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                idx_next = idx_reg + 1'b1;
                if (idx_reg == IW'(TIMERS-1))
                begin
                    if (!fill_reg && req_reg == ketimer_pkg::REQ_CREATE && !bad_reg &&
                        !done_next && freeseen_next)
                    begin
                        fill_next = 1'b1;
                        idx_next  = '0;
                    end
                    else
                    begin
                        state_next = ketimer_pkg::S_REPORT;
                    end
                end
            end
            ketimer_pkg::S_REPORT:
            begin
                state_next = ketimer_pkg::S_IDLE;
            end
            default:
            begin
                state_next = ketimer_pkg::S_IDLE;
            end
        endcase
    end

    logic report_now;
    assign report_now = (state_reg == ketimer_pkg::S_REPORT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ketimer_pkg::S_IDLE;
            idx_reg      <= '0;
            limit_reg    <= 9'd256;
            done_reg     <= 1'b0;
            freeseen_reg <= 1'b0;
            pend_reg     <= 1'b0;
            fill_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            done_reg     <= done_next;
            freeseen_reg <= freeseen_next;
            pend_reg     <= pend_next;
            fill_reg     <= fill_next;
            if (cfg_we)
            begin
                limit_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        pt_reg  <= pt_next;
        pe_reg  <= pe_next;
        if (state_reg == ketimer_pkg::S_IDLE && start)
        begin
            req_reg  <= req_type;
            task_reg <= task_id;
            ev_reg   <= event_req;
            rel_reg  <= reload;
            el_reg   <= elapsed;
            bad_reg  <= ({1'b0, task_id} >= limit_reg) ||
                        ((req_type == ketimer_pkg::REQ_CREATE ||
                          req_type == ketimer_pkg::REQ_UPDATE) && reload == '0) ||
                        (req_type > ketimer_pkg::REQ_TICK);
        end
    end

    // output register
    logic        stb_reg, kind_reg, last_reg;
    logic [1:0]  st_reg;
    logic [7:0]  ot_reg;
    logic [31:0] oe_reg, orem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stb_reg <= 1'b0;
        end
        else
        begin
            stb_reg <= o_stb ||
                       (report_now && (req_reg != ketimer_pkg::REQ_TICK || pend_reg));
        end
    end

    always_ff @(posedge clk)
    begin
        if (report_now)
        begin
            last_reg <= 1'b1;
            orem_reg <= '0;
            if (req_reg == ketimer_pkg::REQ_TICK)
            begin
                kind_reg <= ketimer_pkg::KIND_FIRED;
                st_reg   <= ketimer_pkg::ST_OK;
                ot_reg   <= pt_reg;
                oe_reg   <= pe_reg;
            end
            else
            begin
                kind_reg <= ketimer_pkg::KIND_DONE;
                ot_reg   <= '0;
                oe_reg   <= '0;
                if (bad_reg)
                    st_reg <= ketimer_pkg::ST_INVAL;
                else if (done_reg)
                    st_reg <= ketimer_pkg::ST_OK;
                else if (req_reg == ketimer_pkg::REQ_CREATE)
                    st_reg <= freeseen_reg ? ketimer_pkg::ST_OK : ketimer_pkg::ST_FULL;
                else
                    st_reg <= ketimer_pkg::ST_NOTFOUND;
                if (req_reg == ketimer_pkg::REQ_QUERY && !bad_reg && done_reg)
                    orem_reg <= rem_reg;
            end
        end
        else
        begin
            last_reg <= o_last;
            kind_reg <= o_kind;
            st_reg   <= o_st;
            ot_reg   <= o_task;
            oe_reg   <= o_ev;
            orem_reg <= o_rem;
        end
    end

    assign strobe      = stb_reg;
    assign kind        = kind_reg;
    assign status      = st_reg;
    assign fired_task  = ot_reg;
    assign fired_event = oe_reg;
    assign remaining   = orem_reg;
    assign last        = last_reg;

endmodule

FILE: rtl/keyed_event_timer_table_chk.sv
// Port-level checker for the keyed event timer table.
module keyed_event_timer_table_chk
(
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       strobe,
    input logic       kind,
    input logic [1:0] status,
    input logic       last
);

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("request not taken");

    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && kind == ketimer_pkg::KIND_DONE |-> last)
        else $error("completion without last");

    a_fired_ok: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && kind == ketimer_pkg::KIND_FIRED |-> status == ketimer_pkg::ST_OK)
        else $error("notice with bad status");

    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !busy && !$past(busy) |-> !strobe)
        else $error("result while idle");

endmodule

bind keyed_event_timer_table keyed_event_timer_table_chk u_chk
(
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .strobe (strobe),
    .kind   (kind),
    .status (status),
    .last   (last)
);

FILE: sim/keyed_event_timer_table_test.sv
// Testbench for the keyed event timer table: random and directed requests checked against a predictor.
`timescale 1ns / 1ps
module keyed_event_timer_table_test;

    localparam int TIMERS = 16;

    typedef struct {
        logic [2:0]  req_type;
        logic [7:0]  task_id;
        logic [31:0] event_req;
        logic [31:0] reload;
        logic [7:0]  elapsed;
    } request_t;

    typedef struct {
        logic        kind;
        logic [1:0]  status;
        logic [7:0]  fired_task;
        logic [31:0] fired_event;
        logic [31:0] remaining;
        logic        last;
    } answer_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  req_type;
    logic [7:0]  task_id;
    logic [31:0] event_req;
    logic [31:0] reload;
    logic [7:0]  elapsed;
    logic        cfg_we;
    logic [8:0]  cfg_data;
    logic        strobe;
    logic        kind;
    logic [1:0]  status;
    logic [7:0]  fired_task;
    logic [31:0] fired_event;
    logic [31:0] remaining;
    logic        last;

    request_t pending_requests[$];
    answer_t  expected_answers[$];

    logic [31:0] model_count[TIMERS] = '{default: '0};
    logic [7:0]  model_task[TIMERS] = '{default: '0};
    logic [31:0] model_event[TIMERS] = '{default: '0};
    logic [8:0]  model_limit = 9'd256;

    int mismatches = 0;
    int requests_sent = 0;
    int answers_seen = 0;
    int fired_seen = 0;
    bit quiet_stretch;
    logic busy_at_edge;

    keyed_event_timer_table #(.TIMERS(TIMERS)) dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .req_type(req_type),
        .task_id(task_id),
        .event_req(event_req),
        .reload(reload),
        .elapsed(elapsed),
        .cfg_we(cfg_we),
        .cfg_data(cfg_data),
        .strobe(strobe),
        .kind(kind),
        .status(status),
        .fired_task(fired_task),
        .fired_event(fired_event),
        .remaining(remaining),
        .last(last)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic int find_timer(logic [7:0] t, logic [31:0] e);
        for (int i = 0; i < TIMERS; i++)
        begin
            if (model_count[i] != 0 && model_task[i] == t && model_event[i] == e)
                return i;
        end
        return TIMERS;
    endfunction

    function automatic void push_done(logic [1:0] st, logic [31:0] rem);
        answer_t a;
        a.kind = ketimer_pkg::KIND_DONE;
        a.status = st;
        a.fired_task = '0;
        a.fired_event = '0;
        a.remaining = rem;
        a.last = 1'b1;
        expected_answers.push_back(a);
    endfunction

    function automatic void predict_timers(request_t r);
        bit bad_id;
        int s;
        int first_fired;
        answer_t a;
        bad_id = {1'b0, r.task_id} >= model_limit;
        if (r.req_type == ketimer_pkg::REQ_TICK)
        begin
            if (r.elapsed == 0)
                return;
            first_fired = expected_answers.size();
            for (int i = 0; i < TIMERS; i++)
            begin
                if (model_count[i] != 0)
                begin
                    model_count[i] = model_count[i] >= r.elapsed ?
                                     model_count[i] - r.elapsed : 0;
                    if (model_count[i] == 0)
                    begin
                        a.kind = ketimer_pkg::KIND_FIRED;
                        a.status = ketimer_pkg::ST_OK;
                        a.fired_task = model_task[i];
                        a.fired_event = model_event[i];
                        a.remaining = '0;
                        a.last = 1'b0;
                        expected_answers.push_back(a);
                    end
                end
            end
            if (expected_answers.size() > first_fired)
                expected_answers[expected_answers.size() - 1].last = 1'b1;
            return;
        end
        case (r.req_type)
            ketimer_pkg::REQ_CREATE:
            begin
                if (bad_id || r.reload == 0)
                    push_done(ketimer_pkg::ST_INVAL, 0);
                else
                begin
                    s = find_timer(r.task_id, r.event_req);
                    if (s == TIMERS)
                    begin
                        for (int i = 0; i < TIMERS; i++)
                        begin
                            if (s == TIMERS && model_count[i] == 0)
                                s = i;
                        end
                        if (s < TIMERS)
                        begin
                            model_task[s] = r.task_id;
                            model_event[s] = r.event_req;
                        end
                    end
                    if (s < TIMERS)
                    begin
                        model_count[s] = r.reload;
                        push_done(ketimer_pkg::ST_OK, 0);
                    end
                    else
                        push_done(ketimer_pkg::ST_FULL, 0);
                end
            end
            ketimer_pkg::REQ_UPDATE:
            begin
                s = find_timer(r.task_id, r.event_req);
                if (bad_id || r.reload == 0)
                    push_done(ketimer_pkg::ST_INVAL, 0);
                else if (s < TIMERS)
                begin
                    model_count[s] = r.reload;
                    push_done(ketimer_pkg::ST_OK, 0);
                end
                else
                    push_done(ketimer_pkg::ST_NOTFOUND, 0);
            end
            ketimer_pkg::REQ_DELETE, ketimer_pkg::REQ_QUERY:
            begin
                s = find_timer(r.task_id, r.event_req);
                if (bad_id)
                    push_done(ketimer_pkg::ST_INVAL, 0);
                else if (s == TIMERS)
                    push_done(ketimer_pkg::ST_NOTFOUND, 0);
                else if (r.req_type == ketimer_pkg::REQ_DELETE)
                begin
                    model_count[s] = 0;
                    push_done(ketimer_pkg::ST_OK, 0);
                end
                else
                    push_done(ketimer_pkg::ST_OK, model_count[s]);
            end
            default:
                push_done(ketimer_pkg::ST_INVAL, 0);
        endcase
    endfunction

    // driver: start held until the request is taken
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            req_type <= '0;
            task_id <= '0;
            event_req <= '0;
            reload <= '0;
            elapsed <= '0;
        end
        else
        begin
            if (start && !busy_at_edge)
            begin
                requests_sent <= requests_sent + 1;
            end
            if (start && busy_at_edge)
            begin
                start <= 1'b1;
            end
            else if (pending_requests.size() > 0 &&
                     (quiet_stretch || $urandom_range(99) >= 7))
            begin
                start <= 1'b1;
                req_type <= pending_requests[0].req_type;
                task_id <= pending_requests[0].task_id;
                event_req <= pending_requests[0].event_req;
                reload <= pending_requests[0].reload;
                elapsed <= pending_requests[0].elapsed;
                pending_requests.pop_front();
            end
            else
                start <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        request_t r;
        busy_at_edge <= busy;
        if (rst_n && start && !busy)
        begin
            r.req_type = req_type;
            r.task_id = task_id;
            r.event_req = event_req;
            r.reload = reload;
            r.elapsed = elapsed;
            predict_timers(r);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        answer_t e;
        if (rst_n && strobe)
        begin
            answers_seen++;
            if (kind == ketimer_pkg::KIND_FIRED)
                fired_seen++;
            if (expected_answers.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result kind=%0d status=%0d", kind, status);
            end
            else
            begin
                e = expected_answers.pop_front();
                if (kind !== e.kind || status !== e.status || fired_task !== e.fired_task
                    || fired_event !== e.fired_event || remaining !== e.remaining
                    || last !== e.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp k%0d s%0d t%h e%h r%h l%0d got k%0d s%0d t%h e%h r%h l%0d",
                            e.kind, e.status, e.fired_task, e.fired_event, e.remaining, e.last,
                            kind, status, fired_task, fired_event, remaining, last);
                end
            end
        end
    end

    function automatic void queue_request(logic [2:0] op, logic [7:0] t, logic [31:0] e,
                                          logic [31:0] rl, logic [7:0] el);
        request_t r;
        r.req_type = op;
        r.task_id = t;
        r.event_req = e;
        r.reload = rl;
        r.elapsed = el;
        pending_requests.push_back(r);
    endfunction

    task automatic drain_requests();
        while (pending_requests.size() > 0 || start || busy || expected_answers.size() > 0)
            @(posedge clk);
        repeat (2 * TIMERS + 4) @(posedge clk);
    endtask

    task automatic write_limit(logic [8:0] v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_data <= v;
        model_limit = v;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_phase(int count);
        logic [2:0]  op;
        logic [7:0]  t;
        logic [31:0] e;
        logic [31:0] rl;
        for (int n = 0; n < count; n++)
        begin
            op = $urandom_range(99) < 3 ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
            t = $urandom_range(3) == 0 ? 8'($urandom) : 8'($urandom_range(3));
            e = $urandom_range(3) == 0 ? $urandom : 32'($urandom_range(3));
            case ($urandom_range(9))
                0: rl = 0;
                1: rl = $urandom;
                2: rl = 32'hffff_ffff;
                default: rl = $urandom_range(40, 1);
            endcase
            queue_request(op, t, e, rl,
                $urandom_range(9) == 0 ? 8'($urandom) : 8'($urandom_range(12)));
            while (pending_requests.size() > 4)
                @(posedge clk);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        quiet_stretch = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        queue_request(ketimer_pkg::REQ_QUERY, 8'd0, 32'd0, 32'd0, 8'd0);
        queue_request(ketimer_pkg::REQ_CREATE, 8'd255, 32'hffff_ffff, 32'hffff_ffff, 8'd0);
        queue_request(ketimer_pkg::REQ_CREATE, 8'd1, 32'd5, 32'd0, 8'd0);
        queue_request(ketimer_pkg::REQ_UPDATE, 8'd9, 32'd9, 32'd3, 8'd0);
        queue_request(ketimer_pkg::REQ_DELETE, 8'd9, 32'd9, 32'd0, 8'd0);
        for (int i = 0; i < TIMERS; i++)
            queue_request(ketimer_pkg::REQ_CREATE, 8'(i), 32'(i), 32'(i + 1), 8'd0);
        queue_request(ketimer_pkg::REQ_TICK, 8'd0, 32'd0, 32'd0, 8'd0);
        queue_request(ketimer_pkg::REQ_TICK, 8'd0, 32'd0, 32'd0, 8'd255);
        queue_request(ketimer_pkg::REQ_UPDATE, 8'd255, 32'hffff_ffff, 32'd0, 8'd0);
        queue_request(3'd7, 8'd0, 32'd0, 32'd0, 8'd0);
        drain_requests();

        write_limit(9'd0);
        queue_request(ketimer_pkg::REQ_QUERY, 8'd0, 32'd0, 32'd0, 8'd0);
        queue_request(ketimer_pkg::REQ_CREATE, 8'd0, 32'd1, 32'd2, 8'd0);
        drain_requests();

        write_limit(9'd4);
        random_phase(100);
        drain_requests();
        write_limit(9'd511);
        quiet_stretch = 1'b1;
        random_phase(60);
        quiet_stretch = 1'b0;
        random_phase(40);
        drain_requests();
        write_limit(9'd1);
        random_phase(40);
        drain_requests();
        write_limit(9'd256);
        random_phase(50);
        drain_requests();

        $display("requests sent %0d, results checked %0d (%0d timer expiries)",
            requests_sent, answers_seen, fired_seen);
        if (mismatches == 0 && expected_answers.size() == 0)
            $display("[keyed_event_timer_table] OK");
        else
            $display("[keyed_event_timer_table] ERROR");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("[keyed_event_timer_table] ERROR");
        $finish;
    end
endmodule
